FILE: hdl/lsp2p_pkg.sv
// Package for the lidar polar-to-pixel unit: widths, constants, CORDIC arctangent table.
// No dependencies.
`timescale 1ns / 1ps
package lsp2p_pkg;
  localparam int RangeW = 24;
  localparam int AngW = 16;
  localparam int PxW = 17;
  localparam int ScaleW = 16;
  localparam int IdxW = 12;
  localparam int CordW = 44;
  localparam int ZW = 34;
  localparam int AtanCount = 24;
  localparam int MAX_RAYS_DEF = 4096;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam logic [24:0] InvGainQ24 = 25'd10187995;
  localparam logic signed [CordW-1:0] CentreQ6 = 44'sd19232;
  localparam logic [RangeW-1:0] NearestReset = 24'd102400;
  localparam logic [2:0] RegAngleStart = 3'd0;
  localparam logic [2:0] RegAngleInc = 3'd1;
  localparam logic [2:0] RegRangeFloor = 3'd2;
  localparam logic [2:0] RegRangeCeil = 3'd3;
  localparam logic [2:0] RegScale = 3'd4;

  typedef logic signed [CordW-1:0] cord_t;

  function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'h20000000; 5'd1: v = 32'h12E4051E; 5'd2: v = 32'h09FB385B;
      5'd3: v = 32'h051111D4; 5'd4: v = 32'h028B0D43; 5'd5: v = 32'h0145D7E1;
      5'd6: v = 32'h00A2F61E; 5'd7: v = 32'h00517C55; 5'd8: v = 32'h0028BE53;
      5'd9: v = 32'h00145F2F; 5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3; 5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D; 5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518; 5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146; 5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return signed'({2'b00, v});
  endfunction

  function automatic logic [PxW-1:0] sat_px(input cord_t v);
    if (v < -44'sd65536) return 17'h10000;
    if (v > 44'sd65535) return 17'h0FFFF;
    return v[PxW-1:0];
  endfunction
endpackage

FILE: hdl/lidar_scan_polar_to_pixel_unit.sv
// Top level of the lidar polar-to-pixel unit: config registers, ray tracking, two CORDIC chains.
// Depends on lsp2p_pkg and lsp2p_chain.
`timescale 1ns / 1ps
// One ray at a time: a transfer is taken, then the two CORDIC cell rows (one for the
// start point, one for the end point) advance once per cycle while busy; the result
// appears after the prep registers, the cells and the output register, and the next
// input is taken once that result has been transferred out. Output is registered.
module lidar_scan_polar_to_pixel_unit #(
  parameter int MAX_RAYS = lsp2p_pkg::MAX_RAYS_DEF,
  parameter int CORDIC_STAGES = lsp2p_pkg::CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [lsp2p_pkg::RangeW-1:0] range_sample,
  input  logic sweep_start,
  output logic out_valid,
  input  logic out_ready,
  output logic [lsp2p_pkg::PxW-1:0] start_px_x,
  output logic [lsp2p_pkg::PxW-1:0] start_px_y,
  output logic [lsp2p_pkg::PxW-1:0] end_px_x,
  output logic [lsp2p_pkg::PxW-1:0] end_px_y,
  output logic [lsp2p_pkg::RangeW-1:0] clamped_range,
  output logic at_max_range,
  output logic [lsp2p_pkg::AngW-1:0] ray_angle,
  output logic [lsp2p_pkg::RangeW-1:0] nearest_so_far,
  output logic [lsp2p_pkg::IdxW-1:0] nearest_ray
);
  import lsp2p_pkg::*;
  localparam int CW = $clog2(MAX_RAYS);
  localparam int N = (CORDIC_STAGES > AtanCount) ? AtanCount : CORDIC_STAGES;
  localparam int LAT = N + 3;
  localparam int TW = $clog2(LAT + 1);

  logic [AngW-1:0] angle_start, angle_increment;
  logic [RangeW-1:0] range_floor, range_ceiling;
  logic [ScaleW-1:0] pixels_per_metre;
  logic [CW-1:0] ray_counter, idx;
  logic [RangeW-1:0] nearest_distance, near_base, clamped;
  logic [CW-1:0] nearest_index, near_idx_base;
  logic [AngW-1:0] ang;
  logic busy;
  logic [TW-1:0] timer;
  logic fire, in_fire;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_start <= '0; angle_increment <= '0; range_floor <= '0;
      range_ceiling <= '1; pixels_per_metre <= 16'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegAngleStart: angle_start <= cfg_data[AngW-1:0];
        RegAngleInc: angle_increment <= cfg_data[AngW-1:0];
        RegRangeFloor: range_floor <= cfg_data[RangeW-1:0];
        RegRangeCeil: range_ceiling <= cfg_data[RangeW-1:0];
        RegScale: pixels_per_metre <= cfg_data[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !busy && !out_valid;
  assign in_fire = in_valid && in_ready;
  assign idx = sweep_start ? '0 : ray_counter;
  assign near_base = sweep_start ? NearestReset : nearest_distance;
  assign near_idx_base = sweep_start ? '0 : nearest_index;
  assign ang = AngW'(angle_start + AngW'(32'(idx) * 32'(angle_increment)));
  assign clamped = (range_sample < range_ceiling) ? range_sample : range_ceiling;

  always_ff @(posedge clk) begin
    if (rst) begin
      ray_counter <= '0; nearest_distance <= NearestReset; nearest_index <= '0;
      busy <= 1'b0; timer <= '0; out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (in_fire) begin
        busy <= 1'b1;
        timer <= TW'(LAT);
        ray_counter <= (idx == CW'(MAX_RAYS - 1)) ? '0 : CW'(idx + 1'b1);
        if (clamped < near_base) begin
          nearest_distance <= clamped; nearest_index <= idx;
        end else begin
          nearest_distance <= near_base; nearest_index <= near_idx_base;
        end
      end else if (busy) begin
        timer <= timer - 1'b1;
        if (timer == TW'(1)) begin
          busy <= 1'b0; out_valid <= 1'b1;
        end
      end
    end
  end

  logic [RangeW-1:0] hold_r;
  logic [AngW-1:0] hold_a;
  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_r <= clamped; hold_a <= ang;
      clamped_range <= clamped;
      at_max_range <= (clamped == range_ceiling);
      ray_angle <= ang;
    end
  end
  assign nearest_so_far = nearest_distance;
  assign nearest_ray = IdxW'(32'(nearest_index));

  assign fire = busy;
  lsp2p_chain #(.CORDIC_STAGES(CORDIC_STAGES)) u_start (.clk, .en(fire),
    .r(range_floor), .scale(pixels_per_metre), .ang(hold_a), .px(start_px_x), .py(start_px_y));
  lsp2p_chain #(.CORDIC_STAGES(CORDIC_STAGES)) u_end (.clk, .en(fire),
    .r(hold_r), .scale(pixels_per_metre), .ang(hold_a), .px(end_px_x), .py(end_px_y));

  a_one_item: assert property (@(posedge clk) disable iff (rst) busy |-> !out_valid)
    else $error("busy with result pending");
  a_done: assert property (@(posedge clk) disable iff (rst)
    (busy && timer == TW'(1)) |=> out_valid) else $error("result not raised");
  a_no_take: assert property (@(posedge clk) disable iff (rst) in_fire |=> busy)
    else $error("accepted item not started");
endmodule

FILE: hdl/lsp2p_cell.sv
// One CORDIC micro-rotation cell with a fixed shift; hands x, y, z to its neighbor.
// Depends on lsp2p_pkg.
`timescale 1ns / 1ps
module lsp2p_cell #(
  parameter int SHIFT = 0
) (
  input  logic clk,
  input  logic en,
  input  lsp2p_pkg::cord_t x_in,
  input  lsp2p_pkg::cord_t y_in,
  input  logic signed [lsp2p_pkg::ZW-1:0] z_in,
  output lsp2p_pkg::cord_t x_out,
  output lsp2p_pkg::cord_t y_out,
  output logic signed [lsp2p_pkg::ZW-1:0] z_out
);
  import lsp2p_pkg::*;
  cord_t dx, dy;
  logic signed [ZW-1:0] a;
  assign dx = y_in >>> SHIFT;
  assign dy = x_in >>> SHIFT;
  assign a = atan_val(5'(SHIFT));
  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[ZW-1]) begin
        x_out <= x_in - dx; y_out <= y_in + dy; z_out <= z_in - a;
      end else begin
        x_out <= x_in + dx; y_out <= y_in - dy; z_out <= z_in + a;
      end
    end
  end
endmodule

FILE: hdl/lsp2p_prep.sv
// Front end for one point: scale multiply, inverse-gain multiply, quadrant pre-rotation.
// Depends on lsp2p_pkg.
`timescale 1ns / 1ps
module lsp2p_prep (
  input  logic clk,
  input  logic en,
  input  logic [lsp2p_pkg::RangeW-1:0] r,
  input  logic [lsp2p_pkg::ScaleW-1:0] scale,
  input  logic [lsp2p_pkg::AngW-1:0] ang,
  output lsp2p_pkg::cord_t x0,
  output logic signed [lsp2p_pkg::ZW-1:0] z0
);
  import lsp2p_pkg::*;
  logic [39:0] p;
  logic [AngW-1:0] ang1;
  logic [35:0] q;
  logic signed [ZW-1:0] zr;
  cord_t qx;
  always_ff @(posedge clk) begin
    if (en) begin
      p <= r * scale;
      ang1 <= ang;
    end
  end
  assign q = p[39:4];
  always_comb begin
    qx = signed'(CordW'((61'(q) * 61'(InvGainQ24)) >> 24));
    zr = ZW'(signed'({ang1, 16'd0}));
  end
  // quadrant fold with half-turn: |z| > quarter turn
  always_ff @(posedge clk) begin
    if (en) begin
      if (zr > 34'sd1073741824) begin
        z0 <= zr - 34'sd2147483648; x0 <= -qx;
      end else if (zr < -34'sd1073741824) begin
        z0 <= zr + 34'sd2147483648; x0 <= -qx;
      end else begin
        z0 <= zr; x0 <= qx;
      end
    end
  end
endmodule

FILE: hdl/lsp2p_chain.sv
// Row of CORDIC cells for one point, with rounding and saturation to pixels.
// Depends on lsp2p_pkg, lsp2p_prep, lsp2p_cell.
`timescale 1ns / 1ps
module lsp2p_chain #(
  parameter int CORDIC_STAGES = lsp2p_pkg::CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic en,
  input  logic [lsp2p_pkg::RangeW-1:0] r,
  input  logic [lsp2p_pkg::ScaleW-1:0] scale,
  input  logic [lsp2p_pkg::AngW-1:0] ang,
  output logic [lsp2p_pkg::PxW-1:0] px,
  output logic [lsp2p_pkg::PxW-1:0] py
);
  import lsp2p_pkg::*;
  localparam int N = (CORDIC_STAGES > AtanCount) ? AtanCount : CORDIC_STAGES;
  cord_t xs [N+1];
  cord_t ys [N+1];
  logic signed [ZW-1:0] zs [N+1];
  cord_t xr, yr;
  lsp2p_prep u_prep (.clk, .en, .r, .scale, .ang, .x0(xs[0]), .z0(zs[0]));
  assign ys[0] = '0;
  for (genvar i = 0; i < N; i++) begin : g_cell
    lsp2p_cell #(.SHIFT(i)) u_cell (.clk, .en, .x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]),
      .x_out(xs[i+1]), .y_out(ys[i+1]), .z_out(zs[i+1]));
  end
  assign xr = (xs[N] + 44'sd128) >>> 8;
  assign yr = (ys[N] + 44'sd128) >>> 8;
  always_ff @(posedge clk) begin
    if (en) begin
      px <= sat_px(CentreQ6 + xr);
      py <= sat_px(CentreQ6 - yr);
    end
  end
endmodule
